>>> design/esp_pkg.sv
// Shared types and constants of the encoder speed estimator.
`default_nettype none

package esp_pkg;

    // Field widths of the sample and result transactions.
    localparam int COUNT_W = 32;
    localparam int TIME_W  = 48;
    localparam int ANGLE_W = 64;
    localparam int SPEED_W = 32;
    localparam int ACCEL_W = 48;
    localparam int PPR_W   = 16;
    localparam int CFG_W   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PPR      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CNT16BIT = 1'd1;

    // Speed scale 60e6 * 65536 / 4 = 15e6 * 2^16, applied as a multiply and a shift.
    localparam int MUL_SPEED_W = 24;
    localparam logic [MUL_SPEED_W-1:0] SPEED_MUL = 24'd15000000;
    localparam int SPEED_FRAC = 16;
    localparam int SPEED_PROD_W = COUNT_W + MUL_SPEED_W;

    // Acceleration scale: one million microseconds per second.
    localparam int MUL_ACCEL_W = 20;
    localparam logic [MUL_ACCEL_W-1:0] ACCEL_MUL = 20'd1000000;
    localparam int ACCEL_PROD_W = SPEED_W + MUL_ACCEL_W;

    // Shared divider geometry. One extra step yields the rounding bit.
    localparam int DIV_NUM_W = SPEED_PROD_W + SPEED_FRAC;
    localparam int DIV_DEN_W = TIME_W + PPR_W;
    localparam int DIV_QUO_W = 50;
    localparam int DIV_STEPS = DIV_NUM_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Saturation limits on the rounded quotient magnitude.
    localparam logic [DIV_QUO_W-1:0] SPEED_POS_LIM = DIV_QUO_W'(64'h7FFF_FFFF);
    localparam logic [DIV_QUO_W-1:0] SPEED_NEG_LIM = DIV_QUO_W'(64'h8000_0000);
    localparam logic [DIV_QUO_W-1:0] ACCEL_POS_LIM = DIV_QUO_W'(64'h7FFF_FFFF_FFFF);
    localparam logic [DIV_QUO_W-1:0] ACCEL_NEG_LIM = DIV_QUO_W'(64'h8000_0000_0000);

    // One sample transaction.
    typedef struct packed {
        logic [COUNT_W-1:0] count_now;
        logic [TIME_W-1:0]  time_us;
    } sample_t;

    // One result transaction.
    typedef struct packed {
        logic                      updated;
        logic signed [ANGLE_W-1:0] angle_total;
        logic signed [SPEED_W-1:0] speed_rpm;
        logic signed [ACCEL_W-1:0] accel_rpm_per_s;
    } result_t;

    // Status of the shared divider toward the sequencer.
    typedef struct packed {
        logic done;
        logic overflow;
    } div_stat_t;

endpackage

`default_nettype wire

>>> design/esp_div.sv
// Shared restoring divider: one quotient bit per cycle, plus one rounding bit.
`default_nettype none

module esp_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [esp_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [esp_pkg::DIV_DEN_W-1:0] den,
    output logic      [esp_pkg::DIV_QUO_W-1:0] quo,
    output esp_pkg::div_stat_t                 stat
);

    logic [esp_pkg::DIV_NUM_W-1:0] num_reg;
    logic [esp_pkg::DIV_DEN_W-1:0] den_reg;
    logic [esp_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [esp_pkg::DIV_DEN_W-1:0] rem_next;
    logic [esp_pkg::DIV_QUO_W-1:0] quo_reg;
    logic                          ovf_reg;
    logic [esp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic [esp_pkg::DIV_DEN_W:0]   rem_shift;
    logic [esp_pkg::DIV_DEN_W+1:0] trial;
    logic                          fits;

    // Bring down the next numerator bit and try subtracting the divisor.
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[esp_pkg::DIV_NUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, den_reg};
        fits      = ~trial[esp_pkg::DIV_DEN_W+1];
        rem_next  = fits ? trial[esp_pkg::DIV_DEN_W-1:0]
                         : rem_shift[esp_pkg::DIV_DEN_W-1:0];
    end

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= esp_pkg::DIV_CNT_W'(esp_pkg::DIV_STEPS);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == esp_pkg::DIV_CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand, remainder and quotient registers. Bits shifted out of the
    // quotient are kept as a sticky overflow flag.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[esp_pkg::DIV_NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[esp_pkg::DIV_QUO_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[esp_pkg::DIV_QUO_W-1];
        end
    end

    assign quo           = quo_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

`default_nettype wire

>>> design/encoder_speed_estimator_top.sv
// Top level of the encoder speed estimator: sequencer, state and result register.
//
// Usage: each sample transaction carries a quadrature counter reading and a
// microsecond timestamp. Every sample produces exactly one result transaction.
// If the timestamp did not advance, the result repeats the held angle, speed
// and acceleration with updated low, going from the check state straight to
// the output state.
// Otherwise the count change is added to the angle total, and speed and
// acceleration are each found by one pass through a shared restoring divider
// that settles one quotient bit per cycle (73 steps per division). A sample
// that updates runs through the check, multiply, divide and saturate states
// for speed, then a difference state, then the same for acceleration, then output.
// One sample is in work at a time; sample_stall is high from acceptance
// until the result has been placed in the output register.
// The result register holds while result_stall is high; a sample that
// finishes meanwhile waits behind it in the output state.
// Configuration writes (pulses per revolution, 16-bit counter mode) are
// taken at any edge with cfg_we high and are meant for idle periods.
// Reset clears the angle total, the previous sample, the held speed and
// acceleration, and sets pulses per revolution to one.
`default_nettype none

module encoder_speed_estimator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire esp_pkg::sample_t              sample,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output esp_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [esp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [esp_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MULS,
        ST_GOS,
        ST_WAITS,
        ST_SATS,
        ST_DIFF,
        ST_MULA,
        ST_GOA,
        ST_WAITA,
        ST_SATA,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [esp_pkg::PPR_W-1:0] ppr_reg;
    logic                      cnt16_reg;

    // Persistent estimator state.
    logic [esp_pkg::ANGLE_W-1:0] angle_sum_reg;
    logic [esp_pkg::COUNT_W-1:0] prev_count_reg;
    logic [esp_pkg::TIME_W-1:0]  prev_time_reg;
    logic [esp_pkg::SPEED_W-1:0] prev_speed_reg;
    logic [esp_pkg::ACCEL_W-1:0] held_accel_reg;

    // Per-sample working registers.
    logic [esp_pkg::COUNT_W-1:0]   count_reg;
    logic [esp_pkg::TIME_W-1:0]    time_reg;
    logic [esp_pkg::TIME_W-1:0]    dt_reg;
    logic [esp_pkg::COUNT_W-1:0]   delta_reg;
    logic [esp_pkg::COUNT_W-1:0]   mag_reg;
    logic                          neg_reg;
    logic [esp_pkg::SPEED_W-1:0]   speed_reg;
    logic [esp_pkg::SPEED_W-1:0]   dmag_reg;
    logic                          dneg_reg;
    logic [esp_pkg::DIV_NUM_W-1:0] prod_reg;
    logic [esp_pkg::DIV_DEN_W-1:0] den_reg;
    logic                          upd_reg;

    // Result register.
    logic             result_valid_reg;
    esp_pkg::result_t result_reg;

    // Divider connections.
    logic                          div_start;
    logic [esp_pkg::DIV_QUO_W-1:0] div_quo;
    esp_pkg::div_stat_t            div_stat;

    // Combinational datapath values.
    logic                            time_adv;
    logic [esp_pkg::TIME_W-1:0]      dt_calc;
    logic [esp_pkg::COUNT_W-1:0]     raw_diff;
    logic [esp_pkg::COUNT_W-1:0]     delta_calc;
    logic                            neg_calc;
    logic [esp_pkg::COUNT_W-1:0]     mag_calc;
    logic [esp_pkg::PPR_W-1:0]       ppr_eff;
    logic [esp_pkg::SPEED_PROD_W-1:0] speed_prod;
    logic [esp_pkg::DIV_DEN_W-1:0]   den_calc;
    logic [esp_pkg::DIV_QUO_W-1:0]   rounded;
    logic [esp_pkg::DIV_QUO_W-1:0]   speed_lim;
    logic [esp_pkg::DIV_QUO_W-1:0]   accel_lim;
    logic [esp_pkg::DIV_QUO_W-1:0]   speed_mag;
    logic [esp_pkg::DIV_QUO_W-1:0]   accel_mag;
    logic [esp_pkg::SPEED_W:0]       speed_diff;
    logic [esp_pkg::SPEED_W:0]       diff_mag;
    logic [esp_pkg::ACCEL_PROD_W-1:0] accel_prod;
    logic                            sample_take;
    logic                            result_free;

    assign sample_take = sample_valid && !sample_stall;
    assign result_free = !result_valid_reg || !result_stall;

    // Time step and signed count change, wrapped to 16 bits in that mode.
    always_comb
    begin
        time_adv   = time_reg > prev_time_reg;
        dt_calc    = time_reg - prev_time_reg;
        raw_diff   = count_reg - prev_count_reg;
        delta_calc = cnt16_reg
                   ? {{(esp_pkg::COUNT_W-16){raw_diff[15]}}, raw_diff[15:0]}
                   : raw_diff;
        neg_calc   = delta_calc[esp_pkg::COUNT_W-1];
        mag_calc   = neg_calc ? (~delta_calc + 1'b1) : delta_calc;
        ppr_eff    = (ppr_reg == '0) ? esp_pkg::PPR_W'(1) : ppr_reg;
    end

    // Products that feed the divider; each is registered before use.
    always_comb
    begin
        speed_prod = mag_reg * esp_pkg::SPEED_MUL;
        den_calc   = dt_reg * ppr_eff;
        accel_prod = dmag_reg * esp_pkg::ACCEL_MUL;
    end

    // Round to nearest from the doubled quotient, then clamp to the range.
    always_comb
    begin
        rounded   = {1'b0, div_quo[esp_pkg::DIV_QUO_W-1:1]}
                  + esp_pkg::DIV_QUO_W'(div_quo[0]);
        speed_lim = neg_reg ? esp_pkg::SPEED_NEG_LIM : esp_pkg::SPEED_POS_LIM;
        accel_lim = dneg_reg ? esp_pkg::ACCEL_NEG_LIM : esp_pkg::ACCEL_POS_LIM;
        speed_mag = (div_stat.overflow || rounded > speed_lim) ? speed_lim : rounded;
        accel_mag = (div_stat.overflow || rounded > accel_lim) ? accel_lim : rounded;
    end

    // Speed change against the held speed.
    always_comb
    begin
        speed_diff = {speed_reg[esp_pkg::SPEED_W-1], speed_reg}
                   - {prev_speed_reg[esp_pkg::SPEED_W-1], prev_speed_reg};
        diff_mag   = speed_diff[esp_pkg::SPEED_W] ? (~speed_diff + 1'b1) : speed_diff;
    end

    assign div_start = (state_reg == ST_GOS) || (state_reg == ST_GOA);

    esp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // Sequencer, configuration, estimator state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ppr_reg          <= esp_pkg::PPR_W'(1);
            cnt16_reg        <= 1'b0;
            angle_sum_reg    <= '0;
            prev_count_reg   <= '0;
            prev_time_reg    <= '0;
            prev_speed_reg   <= '0;
            held_accel_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    esp_pkg::REG_PPR:      ppr_reg   <= cfg_data[esp_pkg::PPR_W-1:0];
                    esp_pkg::REG_CNT16BIT: cnt16_reg <= cfg_data[0];
                    default:               ;
                endcase
            end

            // A new result fills the register; otherwise an accepted one leaves it.
            if (state_reg == ST_OUT && result_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_take)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= time_adv ? ST_MULS : ST_OUT;
                end
                ST_MULS:
                begin
                    state_reg <= ST_GOS;
                end
                ST_GOS:
                begin
                    state_reg <= ST_WAITS;
                end
                ST_WAITS:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_SATS;
                    end
                end
                ST_SATS:
                begin
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    state_reg <= ST_MULA;
                end
                ST_MULA:
                begin
                    state_reg <= ST_GOA;
                end
                ST_GOA:
                begin
                    state_reg <= ST_WAITA;
                end
                ST_WAITA:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_SATA;
                    end
                end
                ST_SATA:
                begin
                    // Commit the new sample to the estimator state.
                    held_accel_reg <= dneg_reg ? (~accel_mag[esp_pkg::ACCEL_W-1:0] + 1'b1)
                                               : accel_mag[esp_pkg::ACCEL_W-1:0];
                    angle_sum_reg  <= angle_sum_reg
                                    + {{(esp_pkg::ANGLE_W-esp_pkg::COUNT_W)
                                        {delta_reg[esp_pkg::COUNT_W-1]}}, delta_reg};
                    prev_speed_reg <= speed_reg;
                    prev_count_reg <= count_reg;
                    prev_time_reg  <= time_reg;
                    state_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (result_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working and payload registers; they need no reset.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            count_reg <= sample.count_now;
            time_reg  <= sample.time_us;
        end
        if (state_reg == ST_CHECK)
        begin
            upd_reg   <= time_adv;
            dt_reg    <= dt_calc;
            delta_reg <= delta_calc;
            neg_reg   <= neg_calc;
            mag_reg   <= mag_calc;
        end
        if (state_reg == ST_MULS)
        begin
            prod_reg <= {speed_prod, {esp_pkg::SPEED_FRAC{1'b0}}};
            den_reg  <= den_calc;
        end
        if (state_reg == ST_SATS)
        begin
            speed_reg <= neg_reg ? (~speed_mag[esp_pkg::SPEED_W-1:0] + 1'b1)
                                 : speed_mag[esp_pkg::SPEED_W-1:0];
        end
        if (state_reg == ST_DIFF)
        begin
            dneg_reg <= speed_diff[esp_pkg::SPEED_W];
            dmag_reg <= diff_mag[esp_pkg::SPEED_W-1:0];
        end
        if (state_reg == ST_MULA)
        begin
            prod_reg <= esp_pkg::DIV_NUM_W'(accel_prod);
            den_reg  <= esp_pkg::DIV_DEN_W'(dt_reg);
        end
        if (state_reg == ST_OUT && result_free)
        begin
            result_reg.updated         <= upd_reg;
            result_reg.angle_total     <= angle_sum_reg;
            result_reg.speed_rpm       <= prev_speed_reg;
            result_reg.accel_rpm_per_s <= held_accel_reg;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // The divider reports completion only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_WAITS || state_reg == ST_WAITA))
        else $error("divider finished outside a wait state");

    // An accepted sample blocks further samples in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> sample_stall)
        else $error("second sample accepted while one is in work");

    // The stored timestamp only ever moves forward.
    assert property (@(posedge clk) disable iff (!rst_n)
        (prev_time_reg != $past(prev_time_reg)) |-> (prev_time_reg > $past(prev_time_reg)))
        else $error("stored timestamp moved backward");
`endif

endmodule

`default_nettype wire
